// ----- design/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounding sphere merge package
// Shared widths, transaction types and the per-cell data carried down the
// square root and divider chains.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // Field widths of the Q12.12 format.
  localparam int COORD_BITS = 24;
  localparam int RAD_BITS   = COORD_BITS - 1;

  // Derived arithmetic widths.
  localparam int DIFF_BITS  = COORD_BITS;          // |c2 - c1|
  localparam int SQ_BITS    = 2 * DIFF_BITS + 2;   // sum of three squares
  localparam int ROOT_BITS  = SQ_BITS / 2;         // floor(sqrt(D2))
  localparam int SREM_BITS  = ROOT_BITS + 3;       // root remainder
  localparam int PROD_BITS  = DIFF_BITS + ROOT_BITS; // offset * growth
  localparam int QUOT_BITS  = DIFF_BITS;           // centre shift magnitude
  localparam int DREM_BITS  = ROOT_BITS + 1;       // divider remainder

  // Number of cells in each chain.
  localparam int SQRT_CELLS = ROOT_BITS;
  localparam int DIV_CELLS  = QUOT_BITS;

  // Result case codes.
  localparam logic [1:0] CASE_GENERAL      = 2'd0;
  localparam logic [1:0] CASE_FIRST_HOLDS  = 2'd1;
  localparam logic [1:0] CASE_SECOND_HOLDS = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_centre_x;
    logic signed [COORD_BITS-1:0] first_centre_y;
    logic signed [COORD_BITS-1:0] first_centre_z;
    logic        [RAD_BITS-1:0]   first_radius;
    logic signed [COORD_BITS-1:0] second_centre_x;
    logic signed [COORD_BITS-1:0] second_centre_y;
    logic signed [COORD_BITS-1:0] second_centre_z;
    logic        [RAD_BITS-1:0]   second_radius;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] merged_centre_x;
    logic signed [COORD_BITS-1:0] merged_centre_y;
    logic signed [COORD_BITS-1:0] merged_centre_z;
    logic        [RAD_BITS-1:0]   merged_radius;
    logic        [1:0]            containment_case;
    logic                         radius_saturated;
  } result_t;

  // Per-transaction context that travels alongside the arithmetic.
  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] c1;
    logic [2:0][COORD_BITS-1:0] c2;
    logic [RAD_BITS-1:0]        r1;
    logic [RAD_BITS-1:0]        r2;
    logic [2:0][DIFF_BITS-1:0]  m;
    logic [2:0]                 dir;     // second centre >= first, per axis
    logic                       first;   // first radius is the larger
    logic                       contain; // one sphere holds the other
    logic [ROOT_BITS-1:0]       distance;
    logic [ROOT_BITS-1:0]       grow;
    logic [RAD_BITS-1:0]        rad_out;
    logic                       sat;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [SQ_BITS-1:0]   radicand;
    logic [ROOT_BITS-1:0] root;
    logic [SREM_BITS-1:0] rem;
  } sqrt_t;

  typedef struct packed {
    side_t                      side;
    logic [2:0][QUOT_BITS-1:0]  dvd;
    logic [2:0][DREM_BITS-1:0]  rem;
    logic [2:0][QUOT_BITS-1:0]  quo;
  } div_t;

endpackage

`default_nettype wire

// ----- design/bsm_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// Settles one bit of the integer square root per cell and hands the partial
// root, remainder and context to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire bsm_pkg::sqrt_t data_in,
  output logic               valid_out,
  output bsm_pkg::sqrt_t     data_out
);

  localparam int RB = bsm_pkg::ROOT_BITS;
  localparam int SB = bsm_pkg::SREM_BITS;
  localparam int QB = bsm_pkg::SQ_BITS;

  logic [SB-1:0]  rem_sh;
  logic [SB-1:0]  trial;
  logic           take;
  bsm_pkg::sqrt_t data_next;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {data_in.rem[SB-3:0], data_in.radicand[QB-1 -: 2]};
    trial  = {1'b0, data_in.root, 2'b01};
    take   = (rem_sh >= trial);
    data_next          = data_in;
    data_next.radicand = {data_in.radicand[QB-3:0], 2'b00};
    data_next.root     = {data_in.root[RB-2:0], take};
    data_next.rem      = take ? (rem_sh - trial) : rem_sh;
  end

  // Valid is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

endmodule

`default_nettype wire

// ----- design/bsm_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// Settles one quotient bit for each of the three axes per cell, dividing the
// scaled offset by the centre distance.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_div_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         valid_in,
  input  wire bsm_pkg::div_t data_in,
  output logic              valid_out,
  output bsm_pkg::div_t     data_out
);

  localparam int QB = bsm_pkg::QUOT_BITS;
  localparam int DB = bsm_pkg::DREM_BITS;

  logic [2:0][DB-1:0] rem_sh;
  logic [2:0]         take;
  bsm_pkg::div_t      data_next;

  // Restoring division step on each axis lane.
  always_comb begin
    data_next = data_in;
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {data_in.rem[k][DB-2:0], data_in.dvd[k][QB-1]};
      take[k]   = (rem_sh[k] >= {1'b0, data_in.side.distance});
      data_next.rem[k] = take[k] ? (rem_sh[k] - {1'b0, data_in.side.distance}) : rem_sh[k];
      data_next.quo[k] = {data_in.quo[k][QB-2:0], take[k]};
      data_next.dvd[k] = {data_in.dvd[k][QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

endmodule

`default_nettype wire

// ----- design/bounding_sphere_merge.sv -----
// ----------------------------------------------------------------------------
// Bounding sphere merge
// Smallest sphere enclosing two spheres, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: drive item with the two spheres and raise start. A transaction is
// taken at every rising edge where start is high and busy is low; busy stays
// low, so a new pair may be issued in every cycle.
// Each result is shown on result with done high for exactly one cycle, in
// issue order. The receiver cannot hold results off, and none are needed:
// the pipeline never stalls.
// The pipeline holds two front stages (offsets, then squares), whose sum and
// containment test feed a chain of 25 square root cells (one root bit each),
// two stages for radius and offset products, a chain of 24 divider cells
// (one quotient bit per axis each) and the output register.
// Throughput is one transaction per cycle.
// Reset clears every valid bit in the pipeline; items in flight are dropped
// and done stays low until new transactions arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_sphere_merge (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire bsm_pkg::item_t  item,
  output logic                 done,
  output bsm_pkg::result_t     result
);

  localparam int CB = bsm_pkg::COORD_BITS;
  localparam int RB = bsm_pkg::RAD_BITS;
  localparam int MB = bsm_pkg::DIFF_BITS;
  localparam int QB = bsm_pkg::SQ_BITS;
  localparam int TB = bsm_pkg::ROOT_BITS;
  localparam int PB = bsm_pkg::PROD_BITS;
  localparam int NB = bsm_pkg::QUOT_BITS;
  localparam int DB = bsm_pkg::DREM_BITS;
  localparam int NSQ = bsm_pkg::SQRT_CELLS;
  localparam int NDV = bsm_pkg::DIV_CELLS;

  // The pipeline never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // Stage A: axis offsets and radius difference.
  logic [2:0][CB-1:0] c1_in, c2_in;
  logic [2:0][CB:0]   diff;
  bsm_pkg::side_t     side_a_next, side_a;
  logic [RB-1:0]      rd_next, rd_a;
  logic               valid_a;

  always_comb begin
    c1_in = {item.first_centre_z, item.first_centre_y, item.first_centre_x};
    c2_in = {item.second_centre_z, item.second_centre_y, item.second_centre_x};
    side_a_next = '0;
    side_a_next.c1 = c1_in;
    side_a_next.c2 = c2_in;
    side_a_next.r1 = item.first_radius;
    side_a_next.r2 = item.second_radius;
    side_a_next.first = (item.first_radius > item.second_radius);
    for (int k = 0; k < 3; k++) begin
      diff[k] = {c2_in[k][CB-1], c2_in[k]} - {c1_in[k][CB-1], c1_in[k]};
      side_a_next.dir[k] = ~diff[k][CB];
      side_a_next.m[k]   = diff[k][CB] ? MB'(-diff[k]) : diff[k][MB-1:0];
    end
    rd_next = (item.second_radius >= item.first_radius) ?
              (item.second_radius - item.first_radius) :
              (item.first_radius - item.second_radius);
  end

  // Stage B: squares of the offsets and of the radius difference.
  logic [2:0][2*MB-1:0] sq_b;
  logic [2*RB-1:0]      rd2_b;
  bsm_pkg::side_t       side_b;
  logic                 valid_b;

  // Stage C: squared distance and containment test, start of the root chain.
  logic [QB-1:0]  d2_c;
  bsm_pkg::sqrt_t sq_first;

  always_comb begin
    d2_c = QB'(sq_b[0]) + QB'(sq_b[1]) + QB'(sq_b[2]);
    sq_first          = '0;
    sq_first.side     = side_b;
    sq_first.side.contain = (QB'(rd2_b) >= d2_c);
    sq_first.radicand = d2_c;
  end

  // Square root chain.
  logic           sq_valid [NSQ+1];
  bsm_pkg::sqrt_t sq_data  [NSQ+1];

  // Stage D: merged radius and centre growth.
  bsm_pkg::sqrt_t sq_last;
  logic [TB-1:0]  rad_sum;
  bsm_pkg::side_t side_d_next, side_d;
  logic           valid_d;

  always_comb begin
    sq_last = sq_data[NSQ];
    rad_sum = TB'(({1'b0, sq_last.root} + (TB+1)'(sq_last.side.r1)
                   + (TB+1)'(sq_last.side.r2)) >> 1);
    side_d_next          = sq_last.side;
    side_d_next.distance = sq_last.root;
    side_d_next.grow     = rad_sum - TB'(sq_last.side.r1);
    side_d_next.sat      = |rad_sum[TB-1:RB];
    side_d_next.rad_out  = side_d_next.sat ? {RB{1'b1}} : rad_sum[RB-1:0];
  end

  // Stage E: offset times growth per axis.
  logic [2:0][PB-1:0] prod_e;
  bsm_pkg::side_t     side_e;
  logic               valid_e;
  bsm_pkg::div_t      dv_first;

  always_comb begin
    dv_first      = '0;
    dv_first.side = side_e;
    for (int k = 0; k < 3; k++) begin
      dv_first.rem[k] = DB'(prod_e[k][PB-1:NB]);
      dv_first.dvd[k] = prod_e[k][NB-1:0];
    end
  end

  // Divider chain.
  logic          dv_valid [NDV+1];
  bsm_pkg::div_t dv_data  [NDV+1];

  // Output stage: final centre and case selection.
  bsm_pkg::div_t      dv_last;
  logic [2:0][CB-1:0] centre;
  logic [2:0][CB:0]   moved;
  bsm_pkg::result_t   result_next;

  always_comb begin
    dv_last = dv_data[NDV];
    for (int k = 0; k < 3; k++) begin
      moved[k] = dv_last.side.dir[k] ?
                 ({dv_last.side.c1[k][CB-1], dv_last.side.c1[k]} + {1'b0, dv_last.quo[k]}) :
                 ({dv_last.side.c1[k][CB-1], dv_last.side.c1[k]} - {1'b0, dv_last.quo[k]});
      if (dv_last.side.contain) begin
        centre[k] = dv_last.side.first ? dv_last.side.c1[k] : dv_last.side.c2[k];
      end else if (dv_last.side.distance == '0) begin
        centre[k] = dv_last.side.c1[k];
      end else begin
        centre[k] = moved[k][CB-1:0];
      end
    end
    result_next.merged_centre_x = centre[0];
    result_next.merged_centre_y = centre[1];
    result_next.merged_centre_z = centre[2];
    if (dv_last.side.contain) begin
      result_next.merged_radius    = dv_last.side.first ? dv_last.side.r1 : dv_last.side.r2;
      result_next.containment_case = dv_last.side.first ? bsm_pkg::CASE_FIRST_HOLDS :
                                                          bsm_pkg::CASE_SECOND_HOLDS;
      result_next.radius_saturated = 1'b0;
    end else begin
      result_next.merged_radius    = dv_last.side.rad_out;
      result_next.containment_case = bsm_pkg::CASE_GENERAL;
      result_next.radius_saturated = dv_last.side.sat;
    end
  end

  // Valid bits of the front, middle and output stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_d <= 1'b0;
      valid_e <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_a <= accept;
      valid_b <= valid_a;
      valid_d <= sq_valid[NSQ];
      valid_e <= valid_d;
      done    <= dv_valid[NDV];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    side_a <= side_a_next;
    rd_a   <= rd_next;
    for (int k = 0; k < 3; k++) begin
      sq_b[k] <= side_a.m[k] * side_a.m[k];
    end
    rd2_b  <= rd_a * rd_a;
    side_b <= side_a;
    side_d <= side_d_next;
    for (int k = 0; k < 3; k++) begin
      prod_e[k] <= PB'(side_d.m[k]) * PB'(side_d.grow);
    end
    side_e <= side_d;
    result <= result_next;
  end

  // Chain of root cells.
  assign sq_valid[0] = valid_b;
  assign sq_data[0]  = sq_first;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    bsm_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (sq_valid[i]),
      .data_in   (sq_data[i]),
      .valid_out (sq_valid[i+1]),
      .data_out  (sq_data[i+1])
    );
  end

  // Chain of divider cells.
  assign dv_valid[0] = valid_e;
  assign dv_data[0]  = dv_first;

  for (genvar i = 0; i < NDV; i++) begin : g_div
    bsm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (dv_valid[i]),
      .data_in   (dv_data[i]),
      .valid_out (dv_valid[i+1]),
      .data_out  (dv_data[i+1])
    );
  end

endmodule

`default_nettype wire

// ----- verif/bsm_checker.sv -----
// ----------------------------------------------------------------------------
// Bounding sphere merge checker
// Watches accepted transactions and results, computes the enclosing sphere of
// each accepted pair with exact integer arithmetic, and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            busy,
  input  wire bsm_pkg::item_t  item,
  input  wire logic            done,
  input  wire bsm_pkg::result_t result,
  output int                   errors,
  output int                   pending
);

  localparam int COORD_BITS = bsm_pkg::COORD_BITS;
  localparam int RAD_BITS   = bsm_pkg::RAD_BITS;
  localparam logic [RAD_BITS-1:0] RAD_LIMIT = {RAD_BITS{1'b1}};

  bsm_pkg::result_t merged_q[$];

  // Integer floor square root of a sum of squares.
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  root;
    logic [63:0]  t;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      t = root | (64'd1 << b);
      sq = 128'(t) * 128'(t);
      if (sq <= n) root = t;
    end
    return root;
  endfunction

  // Smallest sphere that encloses both spheres of one pair.
  function automatic bsm_pkg::result_t enclose(bsm_pkg::item_t it);
    bsm_pkg::result_t res;
    logic signed [63:0] c1 [3];
    logic signed [63:0] c2 [3];
    logic [63:0]  m [3];
    logic [127:0] d2;
    logic [127:0] rd2;
    logic [63:0]  r1, r2, rd, distance, rad, grow, mag;
    logic signed [63:0] c;
    logic [127:0] prod;
    c1[0] = it.first_centre_x;  c1[1] = it.first_centre_y;  c1[2] = it.first_centre_z;
    c2[0] = it.second_centre_x; c2[1] = it.second_centre_y; c2[2] = it.second_centre_z;
    r1 = 64'(it.first_radius);
    r2 = 64'(it.second_radius);
    d2 = '0;
    for (int k = 0; k < 3; k++) begin
      m[k] = (c2[k] >= c1[k]) ? 64'(c2[k] - c1[k]) : 64'(c1[k] - c2[k]);
      d2 += 128'(m[k]) * 128'(m[k]);
    end
    rd = (r2 >= r1) ? r2 - r1 : r1 - r2;
    rd2 = 128'(rd) * 128'(rd);
    res = '0;
    if (rd2 >= d2) begin
      // One sphere holds the other; a tie in radius goes to the second.
      if (r1 > r2) begin
        res.merged_centre_x = c1[0][COORD_BITS-1:0];
        res.merged_centre_y = c1[1][COORD_BITS-1:0];
        res.merged_centre_z = c1[2][COORD_BITS-1:0];
        res.merged_radius = r1[RAD_BITS-1:0];
        res.containment_case = bsm_pkg::CASE_FIRST_HOLDS;
      end else begin
        res.merged_centre_x = c2[0][COORD_BITS-1:0];
        res.merged_centre_y = c2[1][COORD_BITS-1:0];
        res.merged_centre_z = c2[2][COORD_BITS-1:0];
        res.merged_radius = r2[RAD_BITS-1:0];
        res.containment_case = bsm_pkg::CASE_SECOND_HOLDS;
      end
    end else begin
      distance = floor_root(d2);
      rad = (distance + r1 + r2) >> 1;
      grow = rad - r1;
      for (int k = 0; k < 3; k++) begin
        c = c1[k];
        if (distance != 0) begin
          prod = 128'(m[k]) * 128'(grow);
          mag = 64'(prod / 128'(distance));
          c = (c2[k] >= c1[k]) ? c + $signed(mag) : c - $signed(mag);
        end
        case (k)
          0: res.merged_centre_x = c[COORD_BITS-1:0];
          1: res.merged_centre_y = c[COORD_BITS-1:0];
          default: res.merged_centre_z = c[COORD_BITS-1:0];
        endcase
      end
      // The radius clamps but the centre keeps the unclamped growth.
      if (rad > 64'(RAD_LIMIT)) begin
        res.merged_radius = RAD_LIMIT;
        res.radius_saturated = 1'b1;
      end else begin
        res.merged_radius = rad[RAD_BITS-1:0];
      end
      res.containment_case = bsm_pkg::CASE_GENERAL;
    end
    return res;
  endfunction

  assign pending = merged_q.size();

  // Record each transaction and compare each result with the oldest one.
  always @(posedge clk) begin
    bsm_pkg::result_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (start && !busy) merged_q.push_back(enclose(item));
      if (done) begin
        if (merged_q.size() == 0) begin
          if (errors < 10) $display("Unexpected result %h", result);
          errors <= errors + 1;
        end else begin
          want = merged_q.pop_front();
          if (result !== want) begin
            if (errors < 10) begin
              $display("Mismatch at %0t", $realtime);
              $display("  expected c=(%h %h %h) r=%h case=%0d sat=%b",
                       want.merged_centre_x, want.merged_centre_y,
                       want.merged_centre_z, want.merged_radius,
                       want.containment_case, want.radius_saturated);
              $display("  actual   c=(%h %h %h) r=%h case=%0d sat=%b",
                       result.merged_centre_x, result.merged_centre_y,
                       result.merged_centre_z, result.merged_radius,
                       result.containment_case, result.radius_saturated);
            end
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

// ----- verif/tb_bounding_sphere_merge.sv -----
// ----------------------------------------------------------------------------
// Bounding sphere merge testbench
// Drives directed and random sphere pairs at varying issue rates and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounding_sphere_merge;

  localparam int COORD_BITS = bsm_pkg::COORD_BITS;
  localparam int RAD_BITS   = bsm_pkg::RAD_BITS;
  localparam int LATENCY = 54;
  localparam int RANDOM_ITEMS = 900;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  bsm_pkg::item_t   item;
  logic             done;
  bsm_pkg::result_t result;
  int               errors;
  int               pending;
  int               idle_pct;
  int               wait_cycles;

  bounding_sphere_merge dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  bsm_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(COORD_BITS-1){1'b0}}};
      1: return {1'b0, {(COORD_BITS-1){1'b1}}};
      2: return COORD_BITS'($signed($urandom_range(0, 8192)) - 4096);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [RAD_BITS-1:0] rand_radius();
    case ($urandom_range(0, 4))
      0: return {RAD_BITS{1'b1}};
      1: return RAD_BITS'($urandom_range(0, 8192));
      default: return RAD_BITS'($urandom);
    endcase
  endfunction

  // Random pair; some have close centres so that they nest, to reach the containment paths.
  function automatic bsm_pkg::item_t rand_pair();
    bsm_pkg::item_t it;
    it.first_centre_x = rand_coord();
    it.first_centre_y = rand_coord();
    it.first_centre_z = rand_coord();
    it.first_radius = rand_radius();
    it.second_radius = rand_radius();
    if ($urandom_range(0, 3) == 0) begin
      it.second_centre_x = it.first_centre_x + COORD_BITS'($urandom_range(0, 255));
      it.second_centre_y = it.first_centre_y - COORD_BITS'($urandom_range(0, 255));
      it.second_centre_z = it.first_centre_z;
    end else begin
      it.second_centre_x = rand_coord();
      it.second_centre_y = rand_coord();
      it.second_centre_z = rand_coord();
    end
    return it;
  endfunction

  function automatic bsm_pkg::item_t make_pair(logic [COORD_BITS-1:0] a,
                                               logic [RAD_BITS-1:0] ra,
                                               logic [COORD_BITS-1:0] b,
                                               logic [RAD_BITS-1:0] rb);
    bsm_pkg::item_t it;
    it = '{a, a, a, ra, b, b, b, rb};
    return it;
  endfunction

  // Issue one transaction, idling first with the given percentage.
  task automatic issue(bsm_pkg::item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    bsm_pkg::item_t it;
    logic [COORD_BITS-1:0] cmin, cmax;
    cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
    cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: equal spheres, nesting both ways, far apart, radius overflow.
    issue(make_pair('0, '0, '0, '0));
    issue(make_pair(24'd100, 23'd500, 24'd100, 23'd500));
    issue(make_pair(24'd0, 23'd9000, 24'd10, 23'd100));
    issue(make_pair(24'd0, 23'd100, 24'd10, 23'd9000));
    issue(make_pair(24'd0, 23'd0, 24'd4096, 23'd0));
    issue(make_pair(cmin, '0, cmax, '0));
    issue(make_pair(cmax, '1, cmin, '1));
    issue(make_pair(cmin, '1, cmax, 23'd1));
    issue(make_pair(cmax, '1, cmax, '0));
    issue(make_pair(cmin, '0, cmin, '1));
    issue(make_pair(24'hFFFFFF, 23'd1, 24'd1, 23'd1));
    it = make_pair(cmin, 23'h2AAAAA, cmax, 23'h555555);
    it.second_centre_y = '0;
    issue(it);

    // Random phases: no idling, heavy idling, then light idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i < 300) ? 0 : (i < 600) ? 66 : 16;
      issue(rand_pair());
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
design/bsm_pkg.sv
design/bsm_sqrt_cell.sv
design/bsm_div_cell.sv
design/bounding_sphere_merge.sv
verif/bsm_checker.sv
verif/tb_bounding_sphere_merge.sv
